/* design/lsmm_pkg.sv */
// Shared types and codes for the load/store memory map.
// Used by every module of the block; no dependencies.
package lsmm_pkg;

  localparam int unsigned DataSizeDef  = 65536;
  localparam int unsigned InstrSizeDef = 65536;

  localparam logic [31:0] InstrBaseRst = 32'h1000_0000;
  localparam logic [31:0] DataBaseRst  = 32'h2000_0000;
  localparam logic [31:0] ConInRst     = 32'h3000_0000;
  localparam logic [31:0] ConOutRst    = 32'h3000_0004;

  // configuration register indexes
  localparam logic [1:0] RegInstrBase = 2'd0;
  localparam logic [1:0] RegDataBase  = 2'd1;
  localparam logic [1:0] RegConIn     = 2'd2;
  localparam logic [1:0] RegConOut    = 2'd3;

  // command codes
  localparam logic [4:0] CmdFetch  = 5'd0;
  localparam logic [4:0] CmdWord   = 5'd1;
  localparam logic [4:0] CmdLeft3  = 5'd4;
  localparam logic [4:0] CmdRight0 = 5'd5;
  localparam logic [4:0] CmdRight3 = 5'd8;
  localparam logic [4:0] CmdLb     = 5'd9;
  localparam logic [4:0] CmdLbu    = 5'd10;
  localparam logic [4:0] CmdLh     = 5'd11;
  localparam logic [4:0] CmdLhu    = 5'd12;
  localparam logic [4:0] CmdSw     = 5'd13;
  localparam logic [4:0] CmdSb     = 5'd14;
  localparam logic [4:0] CmdSh     = 5'd15;
  localparam logic [4:0] CmdLoadI  = 5'd16;

  // exception codes
  localparam logic [2:0] ExcNone     = 3'd0;
  localparam logic [2:0] ExcNullRd   = 3'd1;
  localparam logic [2:0] ExcFetchRng = 3'd2;
  localparam logic [2:0] ExcReadRng  = 3'd3;
  localparam logic [2:0] ExcBadCmd   = 3'd4;
  localparam logic [2:0] ExcWrInstr  = 3'd5;
  localparam logic [2:0] ExcWrNull   = 3'd6;
  localparam logic [2:0] ExcWrRng    = 3'd7;

  typedef struct packed {
    logic [2:0]  exc;
    logic        taken;
    logic        ov;
    logic [7:0]  oc;
    logic [31:0] cv;        // console read value
    logic        mem_rd;
    logic        use_instr;
    logic        dwr;
    logic        iwr;
    logic [31:0] off;       // byte offset into the selected memory
    logic [2:0]  n;         // bytes touched
    logic [1:0]  k;         // left shift in bytes
    logic        sext_b;
    logic        sext_h;
  } dec_t;

endpackage

/* design/lsmm_decode.sv */
// Access decode: console match, region bounds, exceptions, memory offsets.
// Depends on lsmm_pkg.
module lsmm_decode #(
  parameter int unsigned DataSize  = lsmm_pkg::DataSizeDef,
  parameter int unsigned InstrSize = lsmm_pkg::InstrSizeDef
) (
  input  logic [4:0]      command_i,
  input  logic [31:0]     address_i,
  input  logic [31:0]     write_value_i,
  input  logic [7:0]      console_char_i,
  input  logic [31:0]     instr_base_i,
  input  logic [31:0]     data_base_i,
  input  logic [31:0]     con_in_i,
  input  logic [31:0]     con_out_i,
  output lsmm_pkg::dec_t  dec_o
);

  function automatic logic fits(input logic [31:0] a, input logic [1:0] back,
                                input logic [2:0] n, input logic [31:0] base,
                                input logic [32:0] size);
    logic [31:0] s;
    logic [32:0] e;
    s = a - 32'(back);
    e = {1'b0, s - base} + 33'(n);
    return (a >= 32'(back)) && (s >= base) && (e <= size);
  endfunction

  localparam logic [32:0] DSz = 33'(DataSize);
  localparam logic [32:0] ISz = 33'(InstrSize);

  logic [31:0] ci, co, g;
  logic        con;
  logic [1:0]  back;

  assign ci = address_i - con_in_i;
  assign co = address_i - con_out_i;
  assign g  = {{24{console_char_i[7]}}, console_char_i};

  always_comb begin
    dec_o = '0;
    con   = 1'b0;
    back  = 2'd0;
    if (command_i <= lsmm_pkg::CmdLhu) begin
      if (address_i == 32'd0) begin
        dec_o.exc = lsmm_pkg::ExcNullRd;
      end else if (command_i == lsmm_pkg::CmdFetch) begin
        if (fits(address_i, 2'd0, 3'd4, instr_base_i, ISz)) begin
          dec_o.mem_rd    = 1'b1;
          dec_o.use_instr = 1'b1;
          dec_o.off       = address_i - instr_base_i;
          dec_o.n         = 3'd4;
        end else begin
          dec_o.exc = lsmm_pkg::ExcFetchRng;
        end
      end else begin
        if (command_i <= lsmm_pkg::CmdLeft3) begin
          dec_o.k  = 2'(command_i - lsmm_pkg::CmdWord);
          con      = (ci == 32'(dec_o.k));
          dec_o.cv = g << {dec_o.k, 3'b000};
          dec_o.n  = 3'd4 - 3'(dec_o.k);
        end else if (command_i <= lsmm_pkg::CmdRight3) begin
          back     = 2'(command_i - lsmm_pkg::CmdRight0);
          con      = (ci == 32'(back));
          dec_o.cv = g >> (5'd24 - {back, 3'b000});
          dec_o.n  = 3'(back) + 3'd1;
        end else if (command_i <= lsmm_pkg::CmdLbu) begin
          con     = (ci < 32'd4);
          dec_o.n = 3'd1;
          case (ci[1:0])
            2'd0:    dec_o.cv = {24'd0, g[31:24]};
            2'd1:    dec_o.cv = {24'd0, g[23:16]};
            2'd2:    dec_o.cv = {24'd0, g[15:8]};
            default: dec_o.cv = {24'd0, g[7:0]};
          endcase
        end else begin
          con      = (ci == 32'd0) || (ci == 32'd2);
          dec_o.n  = 3'd2;
          dec_o.cv = ci[1] ? {16'd0, g[15:0]} : {16'd0, g[31:16]};
        end
        dec_o.sext_b = (command_i == lsmm_pkg::CmdLb);
        dec_o.sext_h = (command_i == lsmm_pkg::CmdLh);
        if (con) begin
          dec_o.taken = 1'b1;
        end else if (fits(address_i, back, dec_o.n, data_base_i, DSz)) begin
          dec_o.mem_rd = 1'b1;
          dec_o.off    = address_i - 32'(back) - data_base_i;
        end else if (fits(address_i, back, dec_o.n, instr_base_i, ISz)) begin
          dec_o.mem_rd    = 1'b1;
          dec_o.use_instr = 1'b1;
          dec_o.off       = address_i - 32'(back) - instr_base_i;
        end else begin
          dec_o.exc = lsmm_pkg::ExcReadRng;
        end
      end
    end else if (command_i <= lsmm_pkg::CmdSh) begin
      case (command_i)
        lsmm_pkg::CmdSw: dec_o.n = 3'd4;
        lsmm_pkg::CmdSb: dec_o.n = 3'd1;
        default:         dec_o.n = 3'd2;
      endcase
      if (command_i == lsmm_pkg::CmdSw) begin
        if (fits(address_i, 2'd0, 3'd4, data_base_i, DSz)) begin
          dec_o.dwr = 1'b1;
        end else if (co == 32'd0) begin
          dec_o.ov = 1'b1;
          dec_o.oc = write_value_i[7:0];
        end
      end else if (command_i == lsmm_pkg::CmdSb && co < 32'd4) begin
        dec_o.ov = 1'b1;
        dec_o.oc = (co[1:0] == 2'd3) ? write_value_i[7:0] : 8'd0;
      end else if (command_i == lsmm_pkg::CmdSh && (co == 32'd0 || co == 32'd2)) begin
        dec_o.ov = 1'b1;
        dec_o.oc = co[1] ? write_value_i[7:0] : 8'd0;
      end else if (fits(address_i, 2'd0, dec_o.n, data_base_i, DSz)) begin
        dec_o.dwr = 1'b1;
      end
      dec_o.off = address_i - data_base_i;
      if (!dec_o.dwr && !dec_o.ov) begin
        if (fits(address_i, 2'd0, dec_o.n, instr_base_i, ISz)) begin
          dec_o.exc = lsmm_pkg::ExcWrInstr;
        end else if (address_i == 32'd0) begin
          dec_o.exc = lsmm_pkg::ExcWrNull;
        end else begin
          dec_o.exc = lsmm_pkg::ExcWrRng;
        end
      end
    end else if (command_i == lsmm_pkg::CmdLoadI) begin
      dec_o.n   = 3'd1;
      dec_o.off = address_i;
      if ({1'b0, address_i} < ISz) begin
        dec_o.iwr = 1'b1;
      end else begin
        dec_o.exc = lsmm_pkg::ExcWrRng;
      end
    end else begin
      dec_o.exc = lsmm_pkg::ExcBadCmd;
    end
  end

endmodule

/* design/lsmm_mem.sv */
// Four byte banks, one read and one write port each, registered read data.
// Depends on lsmm_pkg for its default size.
module lsmm_mem #(
  parameter int unsigned Size = lsmm_pkg::DataSizeDef,
  localparam int unsigned Depth = (Size + 3) / 4,
  localparam int unsigned RowW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [3:0][RowW-1:0]      rd_row_i,
  input  logic [3:0]                wr_en_i,
  input  logic [3:0][RowW-1:0]      wr_row_i,
  input  logic [3:0][7:0]           wr_data_i,
  output logic [3:0][7:0]           rd_data_o
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [Depth];
    always_ff @(posedge clk_i) begin
      if (wr_en_i[b]) begin
        mem[wr_row_i[b]] <= wr_data_i[b];
      end
      if (rd_en_i) begin
        rd_data_o[b] <= mem[rd_row_i[b]];
      end
    end
  end

endmodule

/* design/load_store_memory_map_top.sv */
// Top level of the load/store memory map: decode, banked memories, result path.
// Depends on lsmm_pkg, lsmm_decode and lsmm_mem.
//
// Use: one access per transaction on the s_axis side (command, address, write
// value, console character); one result per transaction on the m_axis side
// (read value, exception, console taken flag, console output char/valid).
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write them only while the block is idle, which it does not enforce.
// Flow: an accepted access is decoded and memory writes happen at the accept edge;
// the banked read data and the decoded access are registered in the middle stage,
// then bytes are assembled into the output register. Throughput is one access per
// cycle while m_axis_tready_i is high and no clear sweep runs.
// Reset: both memories are swept to zero one row per cycle across the rows of the
// larger memory; s_axis_tready_o stays low until the sweep ends.
// Stall: when m_axis_tready_i is low the output holds, the middle stage fills,
// then s_axis_tready_o drops.
module load_store_memory_map_top #(
  parameter int unsigned DATA_SIZE  = lsmm_pkg::DataSizeDef,
  parameter int unsigned INSTR_SIZE = lsmm_pkg::InstrSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[4:0], address[36:5], write_value[68:37], console_char[76:69]
  input  logic [79:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_value[31:0], exception[34:32], console_char_taken[35],
  // console_out_valid[36], console_out_char[44:37]
  output logic [47:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned DRows = (DATA_SIZE + 3) / 4;
  localparam int unsigned IRows = (INSTR_SIZE + 3) / 4;
  localparam int unsigned DRowW = (DRows > 1) ? $clog2(DRows) : 1;
  localparam int unsigned IRowW = (IRows > 1) ? $clog2(IRows) : 1;
  localparam int unsigned MRows = (DRows > IRows) ? DRows : IRows;
  localparam int unsigned CntW  = $clog2(MRows + 1);

  logic [31:0] instr_base_q, data_base_q, con_in_q, con_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instr_base_q <= lsmm_pkg::InstrBaseRst;
      data_base_q  <= lsmm_pkg::DataBaseRst;
      con_in_q     <= lsmm_pkg::ConInRst;
      con_out_q    <= lsmm_pkg::ConOutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsmm_pkg::RegInstrBase: instr_base_q <= cfg_wdata_i;
        lsmm_pkg::RegDataBase:  data_base_q  <= cfg_wdata_i;
        lsmm_pkg::RegConIn:     con_in_q     <= cfg_wdata_i;
        lsmm_pkg::RegConOut:    con_out_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clearing sweep after reset
  logic            clr_busy_q, clr_busy_d;
  logic [CntW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == CntW'(MRows - 1)) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // handshake
  logic s1_valid_q, out_valid_q, s1_adv, in_acc;

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;

  logic [31:0]    wv;
  lsmm_pkg::dec_t dec;

  assign wv = s_axis_tdata_i[68:37];

  lsmm_decode #(
    .DataSize (DATA_SIZE),
    .InstrSize(INSTR_SIZE)
  ) u_decode (
    .command_i     (s_axis_tdata_i[4:0]),
    .address_i     (s_axis_tdata_i[36:5]),
    .write_value_i (wv),
    .console_char_i(s_axis_tdata_i[76:69]),
    .instr_base_i  (instr_base_q),
    .data_base_i   (data_base_q),
    .con_in_i      (con_in_q),
    .con_out_i     (con_out_q),
    .dec_o         (dec)
  );

  // per-bank row, byte and enable
  logic [3:0][31:0]      bank_pos;
  logic [3:0]            bank_hit;
  logic [3:0][7:0]       bank_byte;
  logic [3:0][DRowW-1:0] d_row, d_wrow;
  logic [3:0][IRowW-1:0] i_row, i_wrow;
  logic [3:0]            d_we, i_we;
  logic [3:0][7:0]       d_wd, i_wd;
  logic [3:0][7:0]       d_rd, i_rd;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [1:0] idx;
      idx          = 2'(b) - dec.off[1:0];
      bank_pos[b]  = dec.off + 32'(idx);
      bank_hit[b]  = 3'(idx) < dec.n;
      bank_byte[b] = 8'(wv >> {(dec.n - 3'd1 - 3'(idx)), 3'b000});
      d_row[b]     = bank_pos[b][DRowW+1:2];
      i_row[b]     = bank_pos[b][IRowW+1:2];
      if (clr_busy_q) begin
        d_we[b]   = clr_cnt_q < CntW'(DRows);
        i_we[b]   = clr_cnt_q < CntW'(IRows);
        d_wrow[b] = clr_cnt_q[DRowW-1:0];
        i_wrow[b] = clr_cnt_q[IRowW-1:0];
        d_wd[b]   = 8'd0;
        i_wd[b]   = 8'd0;
      end else begin
        d_we[b]   = in_acc && dec.dwr && bank_hit[b];
        i_we[b]   = in_acc && dec.iwr && bank_hit[b];
        d_wrow[b] = d_row[b];
        i_wrow[b] = i_row[b];
        d_wd[b]   = bank_byte[b];
        i_wd[b]   = bank_byte[b];
      end
    end
  end

  lsmm_mem #(.Size(DATA_SIZE)) u_dmem (
    .clk_i    (clk_i),
    .rd_en_i  (in_acc),
    .rd_row_i (d_row),
    .wr_en_i  (d_we),
    .wr_row_i (d_wrow),
    .wr_data_i(d_wd),
    .rd_data_o(d_rd)
  );

  lsmm_mem #(.Size(INSTR_SIZE)) u_imem (
    .clk_i    (clk_i),
    .rd_en_i  (in_acc),
    .rd_row_i (i_row),
    .wr_en_i  (i_we),
    .wr_row_i (i_wrow),
    .wr_data_i(i_wd),
    .rd_data_o(i_rd)
  );

  // middle stage
  lsmm_pkg::dec_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= dec;
  end

  // byte assembly
  logic [3:0][7:0] rd_sel;
  logic [31:0]     asm_v, rv;

  always_comb begin
    rd_sel = s1_q.use_instr ? i_rd : d_rd;
    asm_v  = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < s1_q.n) asm_v = {asm_v[23:0], rd_sel[2'(s1_q.off[1:0] + 2'(i))]};
    end
    rv = s1_q.mem_rd ? (asm_v << {s1_q.k, 3'b000}) : s1_q.cv;
    if (s1_q.sext_b) rv = {{24{rv[7]}}, rv[7:0]};
    if (s1_q.sext_h) rv = {{16{rv[15]}}, rv[15:0]};
    if (s1_q.exc != lsmm_pkg::ExcNone || !(s1_q.mem_rd || s1_q.taken)) rv = '0;
  end

  logic [31:0] rv_q;
  logic [2:0]  exc_q;
  logic        taken_q, ov_q;
  logic [7:0]  oc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rv_q    <= rv;
      exc_q   <= s1_q.exc;
      taken_q <= s1_q.taken;
      ov_q    <= s1_q.ov;
      oc_q    <= s1_q.oc;
    end
  end

  assign m_axis_tdata_o = {3'd0, oc_q, ov_q, taken_q, exc_q, rv_q};

`ifndef NO_ASSERTIONS
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready_o) else $error("accept during clear sweep");
  a_exc_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && exc_q != lsmm_pkg::ExcNone) |-> (rv_q == 32'd0 && !taken_q))
    else $error("read data on exception");
  a_held_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(m_axis_tdata_o)))
    else $error("result lost under stall");
  a_no_console_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(taken_q && ov_q)) else $error("console in and out together");
`endif

endmodule

/* tb/load_store_memory_map_checker.sv */
// Checker for the load/store memory map: watches both streams and the config port,
// predicts each result and compares it. Depends on lsmm_pkg.
`timescale 1ns / 100ps
module load_store_memory_map_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [79:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  localparam longint unsigned DSize = lsmm_pkg::DataSizeDef;
  localparam longint unsigned ISize = lsmm_pkg::InstrSizeDef;

  typedef struct packed {
    logic [31:0] rd;
    logic [2:0]  exc;
    logic        taken;
    logic        ov;
    logic [7:0]  oc;
  } access_result_t;

  logic [31:0] instr_base, data_base, con_in, con_out;
  logic [7:0]  data_mem [lsmm_pkg::DataSizeDef];
  logic [7:0]  instr_mem [lsmm_pkg::InstrSizeDef];
  access_result_t expected_q[$];
  int mismatches;

  assign mismatches_o  = mismatches;
  assign outstanding_o = expected_q.size();

  initial begin
    instr_base = lsmm_pkg::InstrBaseRst;
    data_base  = lsmm_pkg::DataBaseRst;
    con_in     = lsmm_pkg::ConInRst;
    con_out    = lsmm_pkg::ConOutRst;
    mismatches = 0;
    foreach (data_mem[i]) data_mem[i] = 8'h00;
    foreach (instr_mem[i]) instr_mem[i] = 8'h00;
  end

  // bounds are computed without wrap; every touched byte must be inside
  function automatic bit in_region(input logic [31:0] a, input int unsigned back,
                                   input int unsigned n, input logic [31:0] base,
                                   input longint unsigned size, output logic [31:0] off);
    longint unsigned s;
    off = '0;
    if (a < back) return 0;
    s = longint'(a) - back;
    if (s < base) return 0;
    if (s - base + n > size) return 0;
    off = 32'(s - base);
    return 1;
  endfunction

  function automatic logic [31:0] read_be(input bit instr, input logic [31:0] off,
                                          input int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++)
      v = (v << 8) | (instr ? instr_mem[off + i] : data_mem[off + i]);
    return v;
  endfunction

  task automatic predict_access(input logic [4:0] cmd, input logic [31:0] addr,
                                input logic [31:0] wv, input logic [7:0] ch,
                                output access_result_t r);
    logic [31:0] g, ci, co, cv, v, off;
    int unsigned back, n, shl, k;
    bit con, done;
    r = '0;
    g = {{24{ch[7]}}, ch};
    ci = addr - con_in;
    co = addr - con_out;
    cv = '0; back = 0; n = 0; shl = 0; con = 0; done = 0;
    if (cmd <= lsmm_pkg::CmdLhu) begin
      if (addr == 0) begin
        r.exc = lsmm_pkg::ExcNullRd;
      end else if (cmd == lsmm_pkg::CmdFetch) begin
        if (in_region(addr, 0, 4, instr_base, ISize, off)) r.rd = read_be(1, off, 4);
        else r.exc = lsmm_pkg::ExcFetchRng;
      end else begin
        if (cmd == lsmm_pkg::CmdWord) begin
          con = (ci == 0); cv = g; n = 4;
        end else if (cmd <= lsmm_pkg::CmdLeft3) begin
          k = cmd - lsmm_pkg::CmdWord;
          con = (ci == k); cv = g << (8 * k); n = 4 - k; shl = 8 * k;
        end else if (cmd <= lsmm_pkg::CmdRight3) begin
          k = cmd - lsmm_pkg::CmdRight0;
          con = (ci == k); cv = g >> (24 - 8 * k); back = k; n = k + 1;
        end else if (cmd <= lsmm_pkg::CmdLbu) begin
          con = (ci < 4);
          if (con) cv = (g >> (24 - 8 * ci[1:0])) & 32'hFF;
          n = 1;
        end else begin
          con = (ci == 0 || ci == 2);
          if (con) cv = (g >> (16 - 8 * ci[1:0])) & 32'hFFFF;
          n = 2;
        end
        if (con) begin
          r.rd = cv; r.taken = 1;
        end else if (in_region(addr, back, n, data_base, DSize, off)) begin
          r.rd = read_be(0, off, n) << shl;
        end else if (in_region(addr, back, n, instr_base, ISize, off)) begin
          r.rd = read_be(1, off, n) << shl;
        end else begin
          r.exc = lsmm_pkg::ExcReadRng;
        end
        if (r.exc == lsmm_pkg::ExcNone) begin
          if (cmd == lsmm_pkg::CmdLb) r.rd = {{24{r.rd[7]}}, r.rd[7:0]};
          if (cmd == lsmm_pkg::CmdLh) r.rd = {{16{r.rd[15]}}, r.rd[15:0]};
        end
      end
    end else if (cmd <= lsmm_pkg::CmdSh) begin
      n = (cmd == lsmm_pkg::CmdSw) ? 4 : (cmd == lsmm_pkg::CmdSb) ? 1 : 2;
      if (cmd == lsmm_pkg::CmdSw) begin
        if (in_region(addr, 0, 4, data_base, DSize, off)) done = 1;
        else if (co == 0) begin
          r.ov = 1; r.oc = wv[7:0]; done = 1;
        end
      end else if (cmd == lsmm_pkg::CmdSb && co < 4) begin
        r.ov = 1; v = wv << (24 - 8 * co[1:0]); r.oc = v[7:0]; done = 1;
      end else if (cmd == lsmm_pkg::CmdSh && (co == 0 || co == 2)) begin
        r.ov = 1; v = wv << (16 - 8 * co[1:0]); r.oc = v[7:0]; done = 1;
      end else if (in_region(addr, 0, n, data_base, DSize, off)) begin
        done = 1;
      end
      if (done && !r.ov)
        for (int i = 0; i < n; i++) data_mem[off + i] = 8'(wv >> (8 * (n - 1 - i)));
      if (!done) begin
        if (in_region(addr, 0, n, instr_base, ISize, off)) r.exc = lsmm_pkg::ExcWrInstr;
        else if (addr == 0) r.exc = lsmm_pkg::ExcWrNull;
        else r.exc = lsmm_pkg::ExcWrRng;
      end
    end else if (cmd == lsmm_pkg::CmdLoadI) begin
      if (addr < ISize) instr_mem[addr] = wv[7:0];
      else r.exc = lsmm_pkg::ExcWrRng;
    end else begin
      r.exc = lsmm_pkg::ExcBadCmd;
    end
    if (r.exc != lsmm_pkg::ExcNone) begin
      r.rd = '0; r.taken = 0;
    end
  endtask

  always @(posedge clk_i) begin
    access_result_t want, got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lsmm_pkg::RegInstrBase: instr_base = cfg_wdata_i;
          lsmm_pkg::RegDataBase:  data_base  = cfg_wdata_i;
          lsmm_pkg::RegConIn:     con_in     = cfg_wdata_i;
          lsmm_pkg::RegConOut:    con_out    = cfg_wdata_i;
          default: ;
        endcase
      end
      // retire first: the result leaving now belongs to an older access
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[31:0], m_axis_tdata_i[34:32], m_axis_tdata_i[35],
               m_axis_tdata_i[36], m_axis_tdata_i[44:37]};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", m_axis_tdata_i);
        end else begin
          want = expected_q.pop_front();
          if (got.rd !== want.rd || got.exc !== want.exc || got.taken !== want.taken ||
              got.ov !== want.ov || got.oc !== want.oc) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp rd=%h exc=%0d taken=%b ov=%b oc=%h, ",
                       want.rd, want.exc, want.taken, want.ov, want.oc,
                       "got rd=%h exc=%0d taken=%b ov=%b oc=%h",
                       got.rd, got.exc, got.taken, got.ov, got.oc);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_access(s_axis_tdata_i[4:0], s_axis_tdata_i[36:5], s_axis_tdata_i[68:37],
                       s_axis_tdata_i[76:69], want);
        expected_q.push_back(want);
      end
    end
  end

endmodule

/* tb/load_store_memory_map_top_tb.sv */
// Testbench top for the load/store memory map: clock, reset, access stimulus
// and config phases. Depends on lsmm_pkg, the block and load_store_memory_map_checker.
`timescale 1ns / 100ps
module load_store_memory_map_top_tb;

  localparam logic [4:0] CmdBadLo = 5'd17;
  localparam logic [4:0] CmdBadHi = 5'd31;
  localparam int unsigned ItemsPerPhase = 340;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [79:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  int          mismatches, outstanding;
  bit          calm = 0;
  int          ready_hold = 0;
  logic [31:0] ibase = lsmm_pkg::InstrBaseRst, dbase = lsmm_pkg::DataBaseRst;
  logic [31:0] cin = lsmm_pkg::ConInRst, cout = lsmm_pkg::ConOutRst;

  always #5 clk_i = ~clk_i;

  load_store_memory_map_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  load_store_memory_map_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_i(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  // mostly short gaps, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_hold <= gap_len() - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic send_access(input logic [4:0] cmd, input logic [31:0] addr,
                             input logic [31:0] wv, input logic [7:0] ch);
    int gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {3'b000, ch, wv, addr, cmd};
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    // let the checker queue the last accepted transaction first
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [31:0] ib, input logic [31:0] db,
                              input logic [31:0] ci, input logic [31:0] co);
    logic [31:0] vals [4];
    vals = '{ib, db, ci, co};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    ibase = ib; dbase = db; cin = ci; cout = co;
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4: return dbase + $urandom_range(0, 63);
      5:             return dbase + 32'd65536 - $urandom_range(1, 6);
      6, 7:          return ibase + $urandom_range(0, 63);
      8:             return ibase + 32'd65536 - $urandom_range(1, 6);
      9:             return cin + $urandom_range(0, 3);
      10:            return cout + $urandom_range(0, 3);
      11:            return $urandom_range(0, 3);
      12:            return dbase - $urandom_range(1, 4);
      default:       return $urandom;
    endcase
  endfunction

  task automatic random_accesses(input int unsigned count);
    int r;
    logic [4:0]  cmd;
    logic [31:0] addr;
    logic [7:0]  ch;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 30)      cmd = $urandom_range(lsmm_pkg::CmdSw, lsmm_pkg::CmdSh);
      else if (r < 70) cmd = $urandom_range(lsmm_pkg::CmdWord, lsmm_pkg::CmdLhu);
      else if (r < 78) cmd = lsmm_pkg::CmdFetch;
      else if (r < 88) cmd = lsmm_pkg::CmdLoadI;
      else if (r < 92) cmd = $urandom_range(CmdBadLo, CmdBadHi);
      else             cmd = $urandom_range(0, 31);
      if (cmd == lsmm_pkg::CmdLoadI) begin
        r = $urandom_range(0, 9);
        addr = (r < 7) ? $urandom_range(0, 63) :
               (r < 9) ? $urandom_range(65530, 65540) : $urandom;
      end else begin
        addr = pick_addr();
      end
      ch = ($urandom_range(0, 7) == 0) ? 8'hFF : $urandom_range(0, 255);
      send_access(cmd, addr, $urandom, ch);
    end
    calm = 0;
  endtask

  task automatic directed_accesses();
    send_access(lsmm_pkg::CmdSw, dbase + 4, 32'h8081_F27F, 8'h00);
    for (logic [4:0] c = lsmm_pkg::CmdWord; c <= lsmm_pkg::CmdLhu; c++)
      send_access(c, dbase + 5, '0, 8'h00);
    for (int i = 0; i < 4; i++) send_access(lsmm_pkg::CmdLoadI, i, 32'hFFFF_FF90 + i, 8'h00);
    send_access(lsmm_pkg::CmdFetch, ibase, '0, 8'h00);
    send_access(lsmm_pkg::CmdLoadI, 32'hFFFF_FFFF, '0, 8'h00);
    send_access(lsmm_pkg::CmdWord, cin, '0, 8'hFF);
    send_access(lsmm_pkg::CmdLb, cin + 3, '0, 8'h80);
    send_access(lsmm_pkg::CmdLh, cin + 2, '0, 8'hFE);
    send_access(lsmm_pkg::CmdSb, cout + 3, 32'hFFFF_FFA5, 8'h00);
    send_access(lsmm_pkg::CmdSh, cout + 2, 32'h0000_005A, 8'h00);
    send_access(lsmm_pkg::CmdSw, cout, 32'h1234_56C3, 8'h00);
    send_access(lsmm_pkg::CmdWord, 32'h0, '0, 8'h00);
    send_access(lsmm_pkg::CmdSb, 32'h0, 32'hFFFF_FFFF, 8'h00);
    send_access(lsmm_pkg::CmdSw, ibase, '0, 8'h00);
    send_access(lsmm_pkg::CmdWord, dbase + 65533, '0, 8'h00);
    send_access(CmdBadLo, $urandom, $urandom, 8'h00);
    send_access(CmdBadHi, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed_accesses();
    random_accesses(ItemsPerPhase);
    drain();
    write_config(32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    random_accesses(ItemsPerPhase);
    drain();
    write_config(32'hFFFF_0000, 32'hFFFE_0000, 32'h0000_0002, 32'hFFFE_0010);
    random_accesses(ItemsPerPhase);
    drain();
    // overlapping regions, console inside data memory
    write_config(32'h4000_0000, 32'h4000_0000, 32'h4000_0010, 32'h4000_0020);
    random_accesses(ItemsPerPhase);
    drain();
    write_config(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0000, 32'h0000_0001);
    random_accesses(ItemsPerPhase);
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
